FILE: src/mep_pkg.sv
package mep_pkg;

	// byte codes
	localparam logic [7:0] NL  = 8'd10;
	localparam logic [7:0] DOT = 8'd46;

	// prefix lengths
	localparam int FROM_LEN = 10;
	localparam int RCPT_LEN = 8;
	localparam int DATA_LEN = 4;

	// recipient limit and widths; only CNT_W is derived from the limit
	localparam int MAX_RECIPIENTS = 1024;
	localparam int CNT_W          = $clog2(MAX_RECIPIENTS + 1);
	localparam int RCPT_IDX_W     = 10;
	localparam int MSG_W          = 16;
	localparam int POS_W          = 4;
	localparam int PHASE_W        = 3;

	// parser phases
	localparam logic [PHASE_W-1:0] PH_SENDER_PFX  = 3'd0;
	localparam logic [PHASE_W-1:0] PH_SENDER_ADDR = 3'd1;
	localparam logic [PHASE_W-1:0] PH_RCPT_PFX    = 3'd2;
	localparam logic [PHASE_W-1:0] PH_RCPT_ADDR   = 3'd3;
	localparam logic [PHASE_W-1:0] PH_DATA_LINE   = 3'd4;
	localparam logic [PHASE_W-1:0] PH_BODY        = 3'd5;
	localparam logic [PHASE_W-1:0] PH_ERROR       = 3'd6;

	// event codes
	typedef enum logic [2:0] {
		EV_SENDER_BYTE = 3'd0,
		EV_SENDER_END  = 3'd1,
		EV_RCPT_BYTE   = 3'd2,
		EV_RCPT_END    = 3'd3,
		EV_DATA        = 3'd4,
		EV_BODY_BYTE   = 3'd5,
		EV_END_MAIL    = 3'd6,
		EV_ERROR       = 3'd7
	} event_t;

	// "MAIL FROM:"
	function automatic logic [7:0] from_char(input logic [POS_W-1:0] pos);
		logic [7:0] c;
		unique case (pos)
			4'd0: c = "M";
			4'd1: c = "A";
			4'd2: c = "I";
			4'd3: c = "L";
			4'd4: c = " ";
			4'd5: c = "F";
			4'd6: c = "R";
			4'd7: c = "O";
			4'd8: c = "M";
			4'd9: c = ":";
			default: c = 8'd0;
		endcase
		return c;
	endfunction

	// "RCPT TO:"
	function automatic logic [7:0] rcpt_char(input logic [POS_W-1:0] pos);
		logic [7:0] c;
		unique case (pos)
			4'd0: c = "R";
			4'd1: c = "C";
			4'd2: c = "P";
			4'd3: c = "T";
			4'd4: c = " ";
			4'd5: c = "T";
			4'd6: c = "O";
			4'd7: c = ":";
			default: c = 8'd0;
		endcase
		return c;
	endfunction

	// "DATA"
	function automatic logic [7:0] data_char(input logic [POS_W-1:0] pos);
		logic [7:0] c;
		unique case (pos)
			4'd0: c = "D";
			4'd1: c = "A";
			4'd2: c = "T";
			4'd3: c = "A";
			default: c = 8'd0;
		endcase
		return c;
	endfunction

endpackage

FILE: src/mail_envelope_and_body_parser.sv
// mail envelope and body parser
// input channel: in_valid / in_ready carry one transcript byte per word,
//   lines ended by a newline byte
// output channel: out_valid / out_ready carry one event word: event_res,
//   out_byte, rcpt_index and message_number
// each input word gives zero or one output word (prefix bytes, blank lines
//   and held body dots give none)
// a byte taken sits in the input register; its event, if any, is written into
//   the output register when the byte leaves the input register
// throughput: one byte per cycle while events are taken; the parse state is
//   updated by short logic between the input register and the output register
// a stalled receiver holds the output register; the input stage still
//   drains bytes that make no event, and a byte that makes an event waits
//   in the input register until the output register is free or being taken
// reset (arst_n low) empties both registers and returns the parser to
//   waiting for a sender line, with recipient and message counts at zero
// a bad prefix or a recipient beyond the limit puts the parser into a
//   sticky error phase where every later byte gives an error event
module mail_envelope_and_body_parser import mep_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            in_byte,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            event_res,
	output logic [7:0]            out_byte,
	output logic [RCPT_IDX_W-1:0] rcpt_index,
	output logic [MSG_W-1:0]      message_number
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// parse state
	logic [PHASE_W-1:0] phase_q,    phase_d;
	logic [POS_W-1:0]   pos_q,      pos_d;
	logic               at_start_q, at_start_d;
	logic               dot_held_q, dot_held_d;
	logic               lone_dot_q, lone_dot_d;
	logic [CNT_W-1:0]   rcpt_cnt_q, rcpt_cnt_d;
	logic [MSG_W-1:0]   msg_done_q, msg_done_d;

	// event of the byte in the input register
	logic                  emit;
	event_t                ev;
	logic [7:0]            ev_byte;
	logic [RCPT_IDX_W-1:0] ev_idx;

	logic out_valid_q;
	logic adv;

	always_comb begin
		phase_d    = phase_q;
		pos_d      = pos_q;
		at_start_d = at_start_q;
		dot_held_d = dot_held_q;
		lone_dot_d = lone_dot_q;
		rcpt_cnt_d = rcpt_cnt_q;
		msg_done_d = msg_done_q;
		emit       = 1'b0;
		ev         = EV_ERROR;
		ev_byte    = 8'd0;
		ev_idx     = '0;

		if (phase_q == PH_ERROR) begin
			emit = 1'b1;
		end else if (at_start_q && byte_s1 == NL) begin
			// blank line, dropped in every phase but the error phase
			emit = 1'b0;
		end else begin
			at_start_d = (byte_s1 == NL);
			unique case (phase_q)
				PH_SENDER_PFX: begin
					if (pos_q >= POS_W'(FROM_LEN) || byte_s1 != from_char(pos_q)) begin
						phase_d = PH_ERROR;
						emit    = 1'b1;
					end else if (pos_q == POS_W'(FROM_LEN - 1)) begin
						phase_d = PH_SENDER_ADDR;
						pos_d   = '0;
					end else begin
						pos_d = pos_q + POS_W'(1);
					end
				end
				PH_SENDER_ADDR: begin
					emit = 1'b1;
					if (byte_s1 == NL) begin
						phase_d = PH_RCPT_PFX;
						pos_d   = '0;
						ev      = EV_SENDER_END;
					end else begin
						ev      = EV_SENDER_BYTE;
						ev_byte = byte_s1;
					end
				end
				PH_RCPT_PFX: begin
					if (pos_q == '0 && byte_s1 == data_char('0)) begin
						// first letter of the data line
						phase_d = PH_DATA_LINE;
						pos_d   = POS_W'(1);
					end else if (pos_q >= POS_W'(RCPT_LEN) ||
							byte_s1 != rcpt_char(pos_q)) begin
						phase_d = PH_ERROR;
						emit    = 1'b1;
					end else if (pos_q == POS_W'(RCPT_LEN - 1)) begin
						// prefix complete: check the recipient limit
						if (rcpt_cnt_q >= CNT_W'(MAX_RECIPIENTS)) begin
							phase_d = PH_ERROR;
							pos_d   = POS_W'(RCPT_LEN);
							emit    = 1'b1;
						end else begin
							phase_d = PH_RCPT_ADDR;
							pos_d   = '0;
						end
					end else begin
						pos_d = pos_q + POS_W'(1);
					end
				end
				PH_RCPT_ADDR: begin
					emit   = 1'b1;
					ev_idx = RCPT_IDX_W'(rcpt_cnt_q);
					if (byte_s1 == NL) begin
						rcpt_cnt_d = rcpt_cnt_q + CNT_W'(1);
						phase_d    = PH_RCPT_PFX;
						pos_d      = '0;
						ev         = EV_RCPT_END;
					end else begin
						ev      = EV_RCPT_BYTE;
						ev_byte = byte_s1;
					end
				end
				PH_DATA_LINE: begin
					if (pos_q < POS_W'(DATA_LEN)) begin
						if (byte_s1 != data_char(pos_q)) begin
							phase_d = PH_ERROR;
							emit    = 1'b1;
						end else begin
							pos_d = pos_q + POS_W'(1);
						end
					end else if (byte_s1 == NL) begin
						// rest of the data line ignored, body starts after it
						phase_d    = PH_BODY;
						pos_d      = '0;
						dot_held_d = 1'b0;
						lone_dot_d = 1'b0;
						emit       = 1'b1;
						ev         = EV_DATA;
					end
				end
				PH_BODY: begin
					if (at_start_q && byte_s1 == DOT) begin
						dot_held_d = 1'b1;
						lone_dot_d = 1'b1;
					end else if (byte_s1 == NL && dot_held_q && lone_dot_q) begin
						// lone dot line closes the message
						dot_held_d = 1'b0;
						lone_dot_d = 1'b0;
						emit       = 1'b1;
						ev         = EV_END_MAIL;
						msg_done_d = msg_done_q + MSG_W'(1);
						phase_d    = PH_SENDER_PFX;
						pos_d      = '0;
						rcpt_cnt_d = '0;
					end else begin
						lone_dot_d = 1'b0;
						if (dot_held_q) begin
							// held dot dropped, this byte passes
							dot_held_d = 1'b0;
							emit       = 1'b1;
							ev         = EV_BODY_BYTE;
							ev_byte    = byte_s1;
						end else if (byte_s1 == DOT) begin
							dot_held_d = 1'b1;
						end else begin
							emit    = 1'b1;
							ev      = EV_BODY_BYTE;
							ev_byte = byte_s1;
						end
					end
				end
				default: begin
					phase_d = PH_ERROR;
					emit    = 1'b1;
				end
			endcase
		end
	end

	// the byte leaves the input register unless its event finds the output full and not being taken
	assign adv      = valid_s1 && (!emit || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_SENDER_PFX;
			pos_q      <= '0;
			at_start_q <= 1'b1;
			dot_held_q <= 1'b0;
			lone_dot_q <= 1'b0;
			rcpt_cnt_q <= '0;
			msg_done_q <= '0;
		end else if (adv) begin
			phase_q    <= phase_d;
			pos_q      <= pos_d;
			at_start_q <= at_start_d;
			dot_held_q <= dot_held_d;
			lone_dot_q <= lone_dot_d;
			rcpt_cnt_q <= rcpt_cnt_d;
			msg_done_q <= msg_done_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			event_res      <= ev;
			out_byte       <= ev_byte;
			rcpt_index     <= ev_idx;
			message_number <= msg_done_q;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_rcpt_limit: assert property (@(posedge clk) disable iff (!arst_n)
		rcpt_cnt_q <= CNT_W'(MAX_RECIPIENTS))
		else $error("recipient count beyond limit");

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_ERROR |=> phase_q == PH_ERROR)
		else $error("error phase left");

	a_msg_count: assert property (@(posedge clk) disable iff (!arst_n)
		adv && emit && ev == EV_END_MAIL |=> msg_done_q == $past(msg_done_q) + MSG_W'(1))
		else $error("message count not advanced at end of mail");

	a_msg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(adv && emit && ev == EV_END_MAIL) |=> $stable(msg_done_q))
		else $error("message count moved without end of mail");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		adv && emit |-> !out_valid_q || out_ready)
		else $error("output register overwritten");
`endif

endmodule

FILE: dv/tb_mail_envelope_and_body_parser.sv
package mep_tb_pkg;
	import mep_pkg::*;

	typedef struct packed {
		event_t                  ev;
		logic [7:0]              data;
		logic [RCPT_IDX_W-1:0]   idx;
		logic [MSG_W-1:0]        msg;
	} event_word_t;

	class envelope_scoreboard;
		string from_pfx = "MAIL FROM:";
		string rcpt_pfx = "RCPT TO:";
		string data_pfx = "DATA";

		logic [PHASE_W-1:0] phase;
		logic [POS_W-1:0]   pos;
		bit                 at_start;
		bit                 dot_held;
		bit                 lone_dot;
		logic [CNT_W-1:0]   rcpt_cnt;
		logic [MSG_W-1:0]   msgs_done;

		event_word_t expected_events[$];
		int          mismatches;

		function new();
			phase      = PH_SENDER_PFX;
			pos        = '0;
			at_start   = 1'b1;
			dot_held   = 1'b0;
			lone_dot   = 1'b0;
			rcpt_cnt   = '0;
			msgs_done  = '0;
			mismatches = 0;
		endfunction

		// advances the parse state by one byte, returns 1 when it makes an event
		function bit parse_byte(input logic [7:0] b, output event_word_t w);
			bit line_start;
			line_start = at_start;
			w.ev   = EV_ERROR;
			w.data = '0;
			w.idx  = '0;
			w.msg  = msgs_done;
			if (phase == PH_ERROR)
				return 1'b1;
			if (line_start && b == NL)
				return 1'b0;
			at_start = (b == NL);
			case (phase)
				PH_SENDER_PFX: begin
					if (b != from_pfx[pos]) begin
						phase = PH_ERROR;
						return 1'b1;
					end
					pos = pos + 1'b1;
					if (pos == FROM_LEN) begin
						phase = PH_SENDER_ADDR;
						pos   = '0;
					end
					return 1'b0;
				end
				PH_SENDER_ADDR: begin
					if (b == NL) begin
						phase = PH_RCPT_PFX;
						pos   = '0;
						w.ev  = EV_SENDER_END;
						return 1'b1;
					end
					w.ev   = EV_SENDER_BYTE;
					w.data = b;
					return 1'b1;
				end
				PH_RCPT_PFX: begin
					if (pos == 0 && b == data_pfx[0]) begin
						phase = PH_DATA_LINE;
						pos   = 1;
						return 1'b0;
					end
					if (b != rcpt_pfx[pos]) begin
						phase = PH_ERROR;
						return 1'b1;
					end
					pos = pos + 1'b1;
					if (pos == RCPT_LEN) begin
						if (rcpt_cnt >= MAX_RECIPIENTS) begin
							phase = PH_ERROR;
							return 1'b1;
						end
						phase = PH_RCPT_ADDR;
						pos   = '0;
					end
					return 1'b0;
				end
				PH_RCPT_ADDR: begin
					w.idx = rcpt_cnt[RCPT_IDX_W-1:0];
					if (b == NL) begin
						rcpt_cnt = rcpt_cnt + 1'b1;
						phase    = PH_RCPT_PFX;
						pos      = '0;
						w.ev     = EV_RCPT_END;
						return 1'b1;
					end
					w.ev   = EV_RCPT_BYTE;
					w.data = b;
					return 1'b1;
				end
				PH_DATA_LINE: begin
					if (pos < DATA_LEN) begin
						if (b != data_pfx[pos]) begin
							phase = PH_ERROR;
							return 1'b1;
						end
						pos = pos + 1'b1;
						return 1'b0;
					end
					if (b == NL) begin
						phase    = PH_BODY;
						pos      = '0;
						dot_held = 1'b0;
						lone_dot = 1'b0;
						w.ev     = EV_DATA;
						return 1'b1;
					end
					return 1'b0;
				end
				PH_BODY: begin
					if (line_start && b == DOT) begin
						dot_held = 1'b1;
						lone_dot = 1'b1;
						return 1'b0;
					end
					if (b == NL && dot_held && lone_dot) begin
						dot_held  = 1'b0;
						lone_dot  = 1'b0;
						w.ev      = EV_END_MAIL;
						msgs_done = msgs_done + 1'b1;
						phase     = PH_SENDER_PFX;
						pos       = '0;
						rcpt_cnt  = '0;
						return 1'b1;
					end
					lone_dot = 1'b0;
					if (dot_held) begin
						dot_held = 1'b0;
						w.ev     = EV_BODY_BYTE;
						w.data   = b;
						return 1'b1;
					end
					if (b == DOT) begin
						dot_held = 1'b1;
						return 1'b0;
					end
					w.ev   = EV_BODY_BYTE;
					w.data = b;
					return 1'b1;
				end
				default: begin
					phase = PH_ERROR;
					return 1'b1;
				end
			endcase
		endfunction

		function void note_byte(input logic [7:0] b);
			event_word_t w;
			if (parse_byte(b, w))
				expected_events.push_back(w);
		endfunction

		function void check_event(input logic [2:0] ev, input logic [7:0] data,
				input logic [RCPT_IDX_W-1:0] idx, input logic [MSG_W-1:0] msg);
			event_word_t w;
			if (expected_events.size() == 0) begin
				$error("unexpected output word: event_res %0d out_byte %0d", ev, data);
				mismatches++;
				return;
			end
			w = expected_events.pop_front();
			if (ev !== w.ev) begin
				$error("event_res: expected %0d, got %0d", w.ev, ev);
				mismatches++;
			end
			if (data !== w.data) begin
				$error("out_byte: expected %0d, got %0d", w.data, data);
				mismatches++;
			end
			if (idx !== w.idx) begin
				$error("rcpt_index: expected %0d, got %0d", w.idx, idx);
				mismatches++;
			end
			if (msg !== w.msg) begin
				$error("message_number: expected %0d, got %0d", w.msg, msg);
				mismatches++;
			end
		endfunction
	endclass

endpackage

module tb_mail_envelope_and_body_parser;
	import mep_pkg::*;
	import mep_tb_pkg::*;

	// stop point for the random transcript, counted in input words
	localparam int RANDOM_BYTES = 1350;
	// cycles without any word moving before the run is declared hung
	localparam int IDLE_LIMIT   = 2000;
	// settle time after the last expected event
	localparam int DRAIN_CYCLES = 20;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [7:0]            in_byte;
	logic                  out_valid;
	logic                  out_ready;
	logic [2:0]            event_res;
	logic [7:0]            out_byte;
	logic [RCPT_IDX_W-1:0] rcpt_index;
	logic [MSG_W-1:0]      message_number;

	envelope_scoreboard sb = new();

	int idle_cycles;
	int bytes_sent;
	// remaining words of a back-to-back stretch, one per side
	int send_burst;
	int take_burst;

	mail_envelope_and_body_parser i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_byte        (in_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.event_res      (event_res),
		.out_byte       (out_byte),
		.rcpt_index     (rcpt_index),
		.message_number (message_number)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// idle gap before the next word: mostly drawn at random, now and then a stretch of words with none
	function automatic int draw_gap(ref int burst);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			burst = $urandom_range(10, 60);
			return 0;
		end
		return $urandom_range(0, 11);
	endfunction

	// any byte but a newline, so a line stays open
	function automatic logic [7:0] text_byte();
		logic [7:0] v;
		v = 8'($urandom_range(0, 254));
		if (v >= NL)
			v = v + 8'd1;
		return v;
	endfunction

	// one input word: idle gap, then hold valid and the byte until taken
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = draw_gap(send_burst);
		repeat (gap) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic send_free(input int n);
		repeat (n)
			send_byte(text_byte());
	endtask

	// empty lines, skipped in every phase but the error phase; only called at a line start
	task automatic maybe_blank();
		if ($urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 2))
				send_byte(NL);
	endtask

	// body line with dots sprinkled in; never a lone dot
	task automatic send_body_line();
		int len;
		logic [7:0] c;
		len = $urandom_range(1, 16);
		for (int i = 0; i < len; i++) begin
			c = ($urandom_range(0, 5) == 0) ? DOT : text_byte();
			send_byte(c);
		end
		if (len == 1 && c == DOT)
			send_byte(text_byte());
		send_byte(NL);
	endtask

	// sender line plus n_rcpt recipient lines
	task automatic send_header(input int n_rcpt);
		maybe_blank();
		send_text("MAIL FROM:");
		send_free($urandom_range(0, 12));
		send_byte(NL);
		repeat (n_rcpt) begin
			maybe_blank();
			send_text("RCPT TO:");
			send_free($urandom_range(0, 12));
			send_byte(NL);
		end
	endtask

	// a whole well-formed message with random content
	task automatic send_message();
		send_header($urandom_range(0, 4));
		maybe_blank();
		send_text("DATA");
		send_free($urandom_range(0, 3));
		send_byte(NL);
		repeat ($urandom_range(0, 5)) begin
			maybe_blank();
			send_body_line();
		end
		maybe_blank();
		send_text(".\n");
	endtask

	// part of a prefix, then a byte that breaks it (a newline now and then)
	task automatic send_bad_prefix();
		int which;
		int k;
		string pfx;
		logic [7:0] c;
		which = $urandom_range(0, 2);
		if (which > 0)
			send_header(which - 1);
		pfx = (which == 0) ? sb.from_pfx : (which == 1) ? sb.rcpt_pfx : sb.data_pfx;
		// a data line must start with its first letter to get past the recipient phase
		k = (which == 2) ? $urandom_range(1, pfx.len() - 1) : $urandom_range(0, pfx.len() - 1);
		for (int i = 0; i < k; i++)
			send_byte(pfx[i]);
		if (k > 0 && $urandom_range(0, 1) == 1)
			c = NL;
		else
			do c = text_byte(); while (c == pfx[k] || (which == 1 && k == 0 && c == "D"));
		send_byte(c);
	endtask

	// scoreboard taps: inputs noted before outputs are checked in the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_byte(in_byte);
			if (out_valid && out_ready)
				sb.check_event(event_res, out_byte, rcpt_index, message_number);
		end
	end

	// hang detection: counts edges at which no word moves on either side
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("[mail_envelope_and_body_parser] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// event receiver: random stall, then ready until one word is taken
	initial begin
		int gap;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			gap = draw_gap(take_burst);
			repeat (gap) begin
				out_ready <= 1'b0;
				@(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	initial begin
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_byte  = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// leading blank line, address bytes at both extremes, empty recipient,
		// junk after data, doubled dot, dropped dots, empty body line
		send_byte(NL);
		send_text("MAIL FROM:");
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(NL);
		send_byte(NL);
		send_text("RCPT TO:\n");
		send_text("DATAx\n");
		send_text("..\n.a.\n\n.\n");
		// no recipients, empty sender and body
		send_text("MAIL FROM:\nDATA\n.\n");

		// random well-formed messages
		while (bytes_sent < RANDOM_BYTES)
			send_message();

		// the error phase is sticky, so one way into it closes the transcript
		send_bad_prefix();
		// every byte after the fault gives an error event
		repeat (20)
			send_byte(8'($urandom_range(0, 255)));
		in_valid <= 1'b0;

		while (sb.expected_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.mismatches == 0 && sb.expected_events.size() == 0)
			$display("[mail_envelope_and_body_parser] OK");
		else
			$display("[mail_envelope_and_body_parser] ERROR");
		$finish;
	end

endmodule
